@@ design/rasum_pkg.sv @@
`timescale 1ns / 1ps
package rasum_pkg;

  localparam int unsigned ENTRIES_DEF = 1024;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = 10;
  // compare width: holds any index and ENTRIES-1 up to 131071
  localparam int unsigned CMP_W       = 17;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PD_A,
    ST_PD_B,
    ST_PD_C,
    ST_PD_D,
    ST_WK_A,
    ST_WK_B,
    ST_WK_C,
    ST_PU_A,
    ST_PU_B,
    ST_PU_C,
    ST_OUT
  } rasum_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_PD_A,
    OP_PD_B,
    OP_PD_C,
    OP_PD_D,
    OP_WK_A,
    OP_WK_B,
    OP_WK_C,
    OP_PU_A,
    OP_PU_B,
    OP_PU_C,
    OP_OUT
  } rasum_op_t;

  typedef struct packed {
    logic clear_done;
    logic in_empty;
    logic in_query;
    logic is_query;
    logic push_last;
    logic a_lt_b;
    logic pull_last;
    logic out_free;
  } rasum_status_t;

endpackage

@@ design/rasum_ctrl.sv @@
`timescale 1ns / 1ps
module rasum_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rasum_pkg::rasum_status_t stat,
  output rasum_pkg::rasum_op_t     op
);

  rasum_pkg::rasum_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rasum_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rasum_pkg::ST_CLEAR: begin
        if (stat.clear_done) state_nxt = rasum_pkg::ST_IDLE;
      end
      rasum_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!stat.in_empty) state_nxt = rasum_pkg::ST_PD_A;
          else if (stat.in_query) state_nxt = rasum_pkg::ST_OUT;
        end
      end
      rasum_pkg::ST_PD_A: state_nxt = rasum_pkg::ST_PD_B;
      rasum_pkg::ST_PD_B: state_nxt = rasum_pkg::ST_PD_C;
      rasum_pkg::ST_PD_C: state_nxt = rasum_pkg::ST_PD_D;
      rasum_pkg::ST_PD_D: begin
        state_nxt = stat.push_last ? rasum_pkg::ST_WK_A : rasum_pkg::ST_PD_A;
      end
      rasum_pkg::ST_WK_A: begin
        if (stat.a_lt_b) state_nxt = rasum_pkg::ST_WK_B;
        else if (stat.is_query) state_nxt = rasum_pkg::ST_OUT;
        else state_nxt = rasum_pkg::ST_PU_A;
      end
      rasum_pkg::ST_WK_B: state_nxt = rasum_pkg::ST_WK_C;
      rasum_pkg::ST_WK_C: state_nxt = rasum_pkg::ST_WK_A;
      rasum_pkg::ST_PU_A: state_nxt = rasum_pkg::ST_PU_B;
      rasum_pkg::ST_PU_B: state_nxt = rasum_pkg::ST_PU_C;
      rasum_pkg::ST_PU_C: begin
        state_nxt = stat.pull_last ? rasum_pkg::ST_IDLE : rasum_pkg::ST_PU_A;
      end
      rasum_pkg::ST_OUT: begin
        if (stat.out_free) state_nxt = rasum_pkg::ST_IDLE;
      end
      default: state_nxt = rasum_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    op       = rasum_pkg::OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      rasum_pkg::ST_CLEAR: op = rasum_pkg::OP_CLEAR;
      rasum_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = rasum_pkg::OP_LOAD;
      end
      rasum_pkg::ST_PD_A: op = rasum_pkg::OP_PD_A;
      rasum_pkg::ST_PD_B: op = rasum_pkg::OP_PD_B;
      rasum_pkg::ST_PD_C: op = rasum_pkg::OP_PD_C;
      rasum_pkg::ST_PD_D: op = rasum_pkg::OP_PD_D;
      rasum_pkg::ST_WK_A: op = rasum_pkg::OP_WK_A;
      rasum_pkg::ST_WK_B: op = rasum_pkg::OP_WK_B;
      rasum_pkg::ST_WK_C: op = rasum_pkg::OP_WK_C;
      rasum_pkg::ST_PU_A: op = rasum_pkg::OP_PU_A;
      rasum_pkg::ST_PU_B: op = rasum_pkg::OP_PU_B;
      rasum_pkg::ST_PU_C: op = rasum_pkg::OP_PU_C;
      rasum_pkg::ST_OUT: begin
        if (stat.out_free) op = rasum_pkg::OP_OUT;
      end
      default: op = rasum_pkg::OP_NONE;
    endcase
  end

  // reset always restarts the clearing sweep
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> state_r == rasum_pkg::ST_CLEAR)
    else $error("reset did not enter clearing sweep");

endmodule

@@ design/rasum_dp.sv @@
`timescale 1ns / 1ps
module rasum_dp #(
  parameter int unsigned ENTRIES = rasum_pkg::ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rasum_pkg::rasum_op_t                op,
  output rasum_pkg::rasum_status_t            stat,
  input  logic                                in_cmd,
  input  logic [rasum_pkg::IDX_W-1:0]         in_left_index,
  input  logic [rasum_pkg::IDX_W-1:0]         in_right_index,
  input  logic signed [rasum_pkg::DATA_W-1:0] in_add_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rasum_pkg::DATA_W-1:0] out_range_sum
);

  localparam int unsigned LEVELS = $clog2(ENTRIES);
  localparam int unsigned LEAVES = 1 << LEVELS;
  localparam int unsigned NW     = LEVELS + 1;
  localparam int unsigned WW     = LEVELS + 2;
  localparam int unsigned LW     = $clog2(LEVELS + 2);
  localparam int unsigned DW     = rasum_pkg::DATA_W;
  localparam int unsigned CW     = rasum_pkg::CMP_W;

  logic [DW-1:0] sum_mem  [2*LEAVES];
  logic [DW-1:0] pend_mem [LEAVES];

  logic              cmd_r;
  logic [LEVELS-1:0] lo_r, hi_r;
  logic [DW-1:0]     amt_r, lazy_r, acc_r, t_r, sum_q, pend_q, out_sum_r;
  logic [WW-1:0]     a_r, b_r;
  logic [NW-1:0]     node_r, clr_r;
  logic [LW-1:0]     lvl_r;
  logic              pass_r, out_valid_r;

  logic [CW-1:0]     lo_ext, hi_ext, hi_sat;
  logic [NW-1:0]     lo_leaf, hi_leaf, push_node, pd_c0, pd_c1, pu_c0, pu_c1;
  logic [NW-1:0]     a_idx, bm1_idx;
  logic [WW-1:0]     bm1;
  logic [LW-1:0]     lvl_m1;
  logic              out_free;

  logic              sum_we, pend_we;
  logic [NW-1:0]     sum_waddr, sum_raddr;
  logic [LEVELS-1:0] pend_waddr, pend_raddr;
  logic [DW-1:0]     sum_wdata, pend_wdata;

  // input range with the right end clipped to the array
  assign lo_ext = CW'(in_left_index);
  assign hi_ext = CW'(in_right_index);
  assign hi_sat = (hi_ext > CW'(ENTRIES - 1)) ? CW'(ENTRIES - 1) : hi_ext;

  assign lo_leaf   = {1'b1, lo_r};
  assign hi_leaf   = {1'b1, hi_r};
  assign push_node = (pass_r ? hi_leaf : lo_leaf) >> lvl_r;
  assign pd_c0     = {push_node[NW-2:0], 1'b0};
  assign pd_c1     = {push_node[NW-2:0], 1'b1};
  assign pu_c0     = {node_r[NW-2:0], 1'b0};
  assign pu_c1     = {node_r[NW-2:0], 1'b1};
  assign a_idx     = a_r[NW-1:0];
  assign bm1       = b_r - WW'(1);
  assign bm1_idx   = bm1[NW-1:0];
  assign lvl_m1    = lvl_r - LW'(1);
  assign out_free  = !out_valid_r || out_ready;

  assign stat.clear_done = &clr_r;
  assign stat.in_empty   = lo_ext > hi_sat;
  assign stat.in_query   = (in_cmd == rasum_pkg::CMD_QUERY);
  assign stat.is_query   = (cmd_r == rasum_pkg::CMD_QUERY);
  assign stat.push_last  = pass_r && (lvl_r == LW'(1));
  assign stat.a_lt_b     = a_r < b_r;
  assign stat.pull_last  = pass_r && (node_r == NW'(1));
  assign stat.out_free   = out_free;

  // memory port steering
  always_comb begin
    sum_we     = 1'b0;
    pend_we    = 1'b0;
    sum_waddr  = pd_c0;
    sum_raddr  = pd_c0;
    pend_waddr = pd_c0[LEVELS-1:0];
    pend_raddr = push_node[LEVELS-1:0];
    sum_wdata  = '0;
    pend_wdata = '0;
    unique case (op)
      rasum_pkg::OP_CLEAR: begin
        sum_we     = 1'b1;
        pend_we    = 1'b1;
        sum_waddr  = clr_r;
        pend_waddr = clr_r[LEVELS-1:0];
      end
      rasum_pkg::OP_PD_A: begin
        sum_raddr  = pd_c0;
        pend_raddr = push_node[LEVELS-1:0];
      end
      rasum_pkg::OP_PD_B: begin
        sum_we     = 1'b1;
        sum_waddr  = pd_c0;
        sum_wdata  = sum_q + (pend_q << lvl_m1);
        pend_we    = 1'b1;
        pend_waddr = push_node[LEVELS-1:0];
        sum_raddr  = pd_c1;
        pend_raddr = pd_c0[LEVELS-1:0];
      end
      rasum_pkg::OP_PD_C: begin
        sum_we     = 1'b1;
        sum_waddr  = pd_c1;
        sum_wdata  = sum_q + (lazy_r << lvl_m1);
        pend_we    = (lvl_r != LW'(1));
        pend_waddr = pd_c0[LEVELS-1:0];
        pend_wdata = pend_q + lazy_r;
        pend_raddr = pd_c1[LEVELS-1:0];
      end
      rasum_pkg::OP_PD_D: begin
        pend_we    = (lvl_r != LW'(1));
        pend_waddr = pd_c1[LEVELS-1:0];
        pend_wdata = pend_q + lazy_r;
      end
      rasum_pkg::OP_WK_A: begin
        sum_raddr  = a_idx;
        pend_raddr = a_idx[LEVELS-1:0];
      end
      rasum_pkg::OP_WK_B: begin
        sum_we     = a_r[0] && (cmd_r == rasum_pkg::CMD_ADD);
        sum_waddr  = a_idx;
        sum_wdata  = sum_q + (amt_r << lvl_r);
        pend_we    = sum_we && (lvl_r != '0);
        pend_waddr = a_idx[LEVELS-1:0];
        pend_wdata = pend_q + amt_r;
        sum_raddr  = bm1_idx;
        pend_raddr = bm1_idx[LEVELS-1:0];
      end
      rasum_pkg::OP_WK_C: begin
        sum_we     = b_r[0] && (cmd_r == rasum_pkg::CMD_ADD);
        sum_waddr  = bm1_idx;
        sum_wdata  = sum_q + (amt_r << lvl_r);
        pend_we    = sum_we && (lvl_r != '0);
        pend_waddr = bm1_idx[LEVELS-1:0];
        pend_wdata = pend_q + amt_r;
      end
      rasum_pkg::OP_PU_A: begin
        sum_raddr  = pu_c0;
        pend_raddr = node_r[LEVELS-1:0];
      end
      rasum_pkg::OP_PU_B: begin
        sum_raddr  = pu_c1;
      end
      rasum_pkg::OP_PU_C: begin
        sum_we     = 1'b1;
        sum_waddr  = node_r;
        sum_wdata  = t_r + sum_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sum_q  <= sum_mem[sum_raddr];
    pend_q <= pend_mem[pend_raddr];
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == rasum_pkg::OP_CLEAR) clr_r <= clr_r + NW'(1);
      out_valid_r <= (out_valid_r && !out_ready) || (op == rasum_pkg::OP_OUT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      rasum_pkg::OP_LOAD: begin
        cmd_r  <= in_cmd;
        lo_r   <= lo_ext[LEVELS-1:0];
        hi_r   <= hi_sat[LEVELS-1:0];
        amt_r  <= in_add_value;
        acc_r  <= '0;
        pass_r <= 1'b0;
        lvl_r  <= LW'(LEVELS);
      end
      rasum_pkg::OP_PD_B: lazy_r <= pend_q;
      rasum_pkg::OP_PD_D: begin
        if (lvl_r == LW'(1)) begin
          if (!pass_r) begin
            pass_r <= 1'b1;
            lvl_r  <= LW'(LEVELS);
          end else begin
            a_r   <= WW'(lo_leaf);
            b_r   <= WW'(hi_leaf) + WW'(1);
            lvl_r <= '0;
          end
        end else begin
          lvl_r <= lvl_m1;
        end
      end
      rasum_pkg::OP_WK_A: begin
        // set up the upward repair in case the walk is over
        if (!stat.a_lt_b) begin
          node_r <= {1'b0, lo_leaf[NW-1:1]};
          lvl_r  <= LW'(1);
          pass_r <= 1'b0;
        end
      end
      rasum_pkg::OP_WK_B: begin
        if (a_r[0]) begin
          a_r <= a_r + WW'(1);
          if (cmd_r == rasum_pkg::CMD_QUERY) acc_r <= acc_r + sum_q;
        end
      end
      rasum_pkg::OP_WK_C: begin
        if (b_r[0] && (cmd_r == rasum_pkg::CMD_QUERY)) acc_r <= acc_r + sum_q;
        a_r   <= a_r >> 1;
        b_r   <= b_r >> 1;
        lvl_r <= lvl_r + LW'(1);
      end
      rasum_pkg::OP_PU_B: t_r <= sum_q + (pend_q << lvl_r);
      rasum_pkg::OP_PU_C: begin
        if (node_r == NW'(1)) begin
          pass_r <= 1'b1;
          node_r <= {1'b0, hi_leaf[NW-1:1]};
          lvl_r  <= LW'(1);
        end else begin
          node_r <= node_r >> 1;
          lvl_r  <= lvl_r + LW'(1);
        end
      end
      rasum_pkg::OP_OUT: out_sum_r <= acc_r;
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (op == rasum_pkg::OP_WK_A) |-> (a_r <= b_r))
    else $error("range walk bounds crossed");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (op == rasum_pkg::OP_OUT) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

endmodule

@@ design/range_add_range_sum_tree_unit.sv @@
`timescale 1ns / 1ps
// Range-add / range-sum store over ENTRIES signed 32-bit elements, kept as a
// bottom-up lazy segment tree in two single-port-read memories (node sums,
// 2*LEAVES words, and pending adds, LEAVES words). After reset the block runs
// a clearing sweep over all 2*LEAVES node addresses with in_ready low. Each
// item then goes through a controller that walks the tree: a push of pending
// adds along both end leaves (states PD_A to PD_D per level, two paths), the
// range walk (states WK_A to WK_C per level, then a final WK_A), and for adds
// a pull back up both paths (states PU_A to PU_C per level). A query instead
// loads the result register. Narrower ranges can finish the walk at a lower
// level. An empty add is accepted with no tree walk, and an empty query goes
// straight to the result register load.
// The tree visits are serialised by the one read port per memory.
// Right index above ENTRIES-1 is clipped; an empty range adds nothing and
// queries give 0. All sums wrap modulo 2^32. A finished query result waits in
// an output register while the next item is accepted.
module range_add_range_sum_tree_unit #(
  parameter int unsigned ENTRIES = rasum_pkg::ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [rasum_pkg::IDX_W-1:0]         in_left_index,
  input  logic [rasum_pkg::IDX_W-1:0]         in_right_index,
  input  logic signed [rasum_pkg::DATA_W-1:0] in_add_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rasum_pkg::DATA_W-1:0] out_range_sum
);

  // command from the sequencer, status back from the tree datapath
  rasum_pkg::rasum_op_t     op;
  rasum_pkg::rasum_status_t stat;

  rasum_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  rasum_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .in_add_value   (in_add_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_range_sum  (out_range_sum)
  );

endmodule
